// ===== rtl/core/uaft_pkg.sv =====
// ----------------------------------------------------------------------------
// uaft_pkg
// Shared types and codes of the use-after-free tracker: item structs,
// operation modes and result status codes.
// ----------------------------------------------------------------------------
package uaft_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned USED_W = 9;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_RSVD      = 2'd3
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [ADDR_W-1:0]  address;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               dangling;
    logic [ID_W-1:0]    entry_id;
    logic [USED_W-1:0]  entries_used;
  } out_item_t;

endpackage

// ===== rtl/core/uaft_table.sv =====
// ----------------------------------------------------------------------------
// uaft_table
// Slot memory: one stored address plus freed mark per slot. One write port
// and one read port, read data registered.
// ----------------------------------------------------------------------------
module uaft_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned IDX_W  = 8,
  parameter int unsigned DATA_W = 65
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== rtl/core/use_after_free_tracker.sv =====
// Allocate and unused-mode items go from the scan state straight to the
// result state; free and query items first scan the filled slots in order.
// Throughput: one item at a time; the scan reads one slot per cycle from the
// single read port of the slot memory.
// Reset clears the fill count and control state only; slot contents are not
// cleared since slots are read only after they are written.
// ----------------------------------------------------------------------------
// use_after_free_tracker
// Tracks allocated pointers in a slot table and reports allocations into a
// full table, frees of pointers with no live slot and queries of dangling (freed) pointers.
// ----------------------------------------------------------------------------
module use_after_free_tracker #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned ADDR_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uaft_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uaft_pkg::out_item_t  out_data
);

  import uaft_pkg::*;

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W = ADDR_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t                state, state_next;
  mode_t                 mode;
  logic [ADDR_BITS-1:0]  addr;
  logic [CNT_W-1:0]      fill_count, fill_next;
  logic [CNT_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  rd_vld;
  logic                  found;
  logic [IDX_W-1:0]      hit_idx;

  logic                  rd_en;
  logic [DATA_W-1:0]     rd_data;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [DATA_W-1:0]     wr_data;

  logic                  scanning;
  logic                  more;
  logic                  match;
  logic                  out_free;
  logic                  is_full;
  out_item_t             result;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign is_full  = (fill_count == CNT_W'(CAPACITY));

  assign scanning = (mode == MODE_FREE) || (mode == MODE_QUERY);
  assign more     = scanning && (rd_idx < fill_count);
  // free wants a live slot, query wants a freed one
  assign match    = rd_vld && (rd_data[ADDR_BITS-1:0] == addr) &&
                    (rd_data[ADDR_BITS] == (mode == MODE_QUERY));

  assign rd_en = (state == S_SCAN) && !match && more;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || (!more && !rd_vld)) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result     = '0;
    fill_next  = fill_count;
    wr_en      = 1'b0;
    wr_idx     = fill_count[IDX_W-1:0];
    wr_data    = {1'b0, addr};
    case (mode)
      MODE_ALLOC: begin
        if (is_full) begin
          result.status = STATUS_FULL;
        end else begin
          wr_en           = 1'b1;
          fill_next       = fill_count + 1'b1;
          result.entry_id = ID_W'(fill_count);
        end
      end
      MODE_FREE: begin
        if (found) begin
          wr_en           = 1'b1;
          wr_idx          = hit_idx;
          wr_data         = {1'b1, addr};
          result.entry_id = ID_W'(hit_idx);
        end else begin
          result.status = STATUS_NOT_FOUND;
        end
      end
      MODE_QUERY: begin
        result.dangling = found;
      end
      default: ;
    endcase
    result.entries_used = USED_W'(fill_next);
    if (!((state == S_RESULT) && out_free)) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rd_vld <= 1'b0;
            found  <= 1'b0;
          end
        end
        S_SCAN: begin
          rd_vld <= rd_en;
          if (match) begin
            found <= 1'b1;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            fill_count <= fill_next;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and scan pointers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode   <= in_data.mode;
      addr   <= in_data.address[ADDR_BITS-1:0];
      rd_idx <= '0;
    end
    if (rd_en) begin
      rd_idx  <= rd_idx + 1'b1;
      cmp_idx <= rd_idx[IDX_W-1:0];
    end
    if ((state == S_SCAN) && match) begin
      hit_idx <= cmp_idx;
    end
    if ((state == S_RESULT) && out_free) begin
      out_data <= result;
    end
  end

  uaft_table #(
    .DEPTH  (CAPACITY),
    .IDX_W  (IDX_W),
    .DATA_W (DATA_W)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

endmodule

// ===== tb/tb_use_after_free_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_use_after_free_tracker
// Self-checking bench for the pointer tracking table. A shadow copy of the
// slot table predicts every reply; directed items cover empty-table,
// duplicate, double-free and extreme-address cases, then random
// alloc/free/query traffic grows the table past full. Both channels idle
// in bursts, the receiver holds off once for a long stretch and the sender
// waits once for the pipe to drain.
// ----------------------------------------------------------------------------
module tb_use_after_free_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import uaft_pkg::*;

  localparam int unsigned TRK_CAPACITY  = 256;
  localparam int unsigned TRK_ADDR_BITS = 64;
  localparam logic [ADDR_W-1:0] TRK_ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - TRK_ADDR_BITS);
  localparam int RANDOM_ITEMS   = 900;
  localparam int DRAIN_AT       = 450;
  localparam int LONG_HOLD_AT   = 150;
  localparam int LONG_HOLD_LEN  = 300;
  localparam int QUIET_TAIL     = 80;
  localparam int TAIL_CYCLES    = TRK_CAPACITY + 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    in_item_t item;
    bit       drain;
  } pending_item_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  pending_item_t     pending[$];
  logic [ADDR_W-1:0] alloc_pool[$];
  out_item_t         expected_replies[$];

  // shadow of the slot table
  logic [ADDR_W-1:0] shadow_addr[TRK_CAPACITY];
  bit                shadow_freed[TRK_CAPACITY];
  int unsigned       shadow_fill = 0;

  int total_items   = 0;
  int items_issued  = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int rx_count      = 0;
  int fail_count    = 0;
  int tx_gap        = 0;
  int rx_hold       = 0;
  bit long_hold_done = 1'b0;
  int stall_cycles  = 0;

  use_after_free_tracker #(
    .CAPACITY (TRK_CAPACITY),
    .ADDR_BITS(TRK_ADDR_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t shadow_table_step(in_item_t it);
    out_item_t         res;
    logic [ADDR_W-1:0] key;
    res = '0;
    key = it.address & TRK_ADDR_MASK;
    case (it.mode)
      MODE_ALLOC: begin
        if (shadow_fill >= TRK_CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_addr[shadow_fill]  = key;
          shadow_freed[shadow_fill] = 1'b0;
          res.entry_id = ID_W'(shadow_fill);
          shadow_fill++;
        end
      end
      MODE_FREE: begin
        res.status = STATUS_NOT_FOUND;
        // lowest live slot holding the pointer gets freed
        for (int s = 0; s < shadow_fill; s++) begin
          if (shadow_addr[s] == key && !shadow_freed[s]) begin
            shadow_freed[s] = 1'b1;
            res.status = STATUS_DONE;
            res.entry_id = ID_W'(s);
            break;
          end
        end
      end
      MODE_QUERY: begin
        for (int s = 0; s < shadow_fill; s++) begin
          if (shadow_addr[s] == key && shadow_freed[s]) begin
            res.dangling = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    res.entries_used = USED_W'(shadow_fill);
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] random_pointer();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(ADDR_W-1){1'b0}}};
      3:       return {{(ADDR_W-1){1'b0}}, 1'b1} << $urandom_range(0, ADDR_W-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pooled_pointer();
    if (alloc_pool.size() == 0) return random_pointer();
    return alloc_pool[$urandom_range(0, alloc_pool.size()-1)];
  endfunction

  // no idling near the end, and every fourth stretch runs flat out
  function automatic bit idle_ok(int idx);
    return idx < total_items - QUIET_TAIL && ((idx / 60) % 4) != 3;
  endfunction

  task automatic add_item(mode_t m, logic [ADDR_W-1:0] a);
    pending_item_t p;
    p.item.mode    = m;
    p.item.address = a;
    p.drain        = (pending.size() == DRAIN_AT);
    if (m == MODE_ALLOC) alloc_pool.push_back(a);
    pending.push_back(p);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit            holding;
    bit            next_valid;
    pending_item_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) items_taken <= items_taken + 1;
      holding = in_valid && !in_ready;
      if (!holding) begin
        next_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending.size() > 0 &&
                     !(pending[0].drain &&
                       results_seen != items_taken + int'(in_valid && in_ready))) begin
          cur = pending.pop_front();
          in_data <= cur.item;
          next_valid = 1'b1;
          if (idle_ok(items_issued) && $urandom_range(0, 3) == 0)
            tx_gap = $urandom_range(1, 15);
          items_issued++;
        end
        in_valid <= next_valid;
      end
    end
  end

  // monitor: predicts on input acceptance, checks on output acceptance
  always @(posedge clk) begin
    out_item_t want;
    bit        next_ready;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_replies.push_back(shadow_table_step(in_data));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply with no item waiting: %p", out_data);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("dangling", 64'(want.dangling), 64'(out_data.dangling));
          check_field("entry_id", 64'(want.entry_id), 64'(out_data.entry_id));
          check_field("entries_used", 64'(want.entries_used), 64'(out_data.entries_used));
        end
        rx_count++;
      end
      results_seen <= rx_count;
      next_ready = 1'b1;
      if (rx_hold > 0) begin
        rx_hold--;
        next_ready = 1'b0;
      end else if (!long_hold_done && rx_count >= LONG_HOLD_AT) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD_LEN - 1;
        next_ready = 1'b0;
      end else if (idle_ok(rx_count) && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(0, 14);
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [ADDR_W-1:0] a;
    int                kind;
    int                goal;
    // empty table, duplicates, repeated free, extremes, unused mode
    add_item(MODE_QUERY, '0);
    add_item(MODE_FREE, '0);
    add_item(MODE_ALLOC, '0);
    add_item(MODE_ALLOC, '1);
    add_item(MODE_ALLOC, '0);
    add_item(MODE_QUERY, '0);
    add_item(MODE_FREE, '0);
    add_item(MODE_QUERY, '0);
    add_item(MODE_FREE, '0);
    add_item(MODE_FREE, '0);
    add_item(MODE_FREE, '1);
    add_item(MODE_QUERY, '1);
    add_item(MODE_QUERY, {(ADDR_W/2){2'b01}});
    add_item(MODE_UNUSED, {(ADDR_W/2){2'b10}});
    add_item(MODE_ALLOC, {(ADDR_W/2){2'b10}});
    add_item(MODE_ALLOC, {(ADDR_W/2){2'b01}});
    add_item(MODE_FREE, {1'b1, {(ADDR_W-1){1'b0}}});
    add_item(MODE_ALLOC, {1'b1, {(ADDR_W-1){1'b0}}});
    add_item(MODE_FREE, {1'b1, {(ADDR_W-1){1'b0}}});
    add_item(MODE_QUERY, {1'b1, {(ADDR_W-1){1'b0}}});
    add_item(MODE_UNUSED, '1);
    add_item(MODE_FREE, {(ADDR_W/2){2'b01}});
    add_item(MODE_QUERY, {(ADDR_W/2){2'b10}});

    goal = pending.size() + RANDOM_ITEMS;
    while (pending.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        a = ($urandom_range(0, 4) == 0) ? pooled_pointer() : random_pointer();
        add_item(MODE_ALLOC, a);
      end else if (kind < 60) begin
        add_item(MODE_FREE, pooled_pointer());
      end else if (kind < 80) begin
        add_item(MODE_QUERY, pooled_pointer());
      end else if (kind < 85) begin
        add_item(MODE_FREE, random_pointer());
      end else if (kind < 92) begin
        add_item(MODE_QUERY, random_pointer());
      end else if (kind < 95) begin
        add_item(MODE_UNUSED, random_pointer());
      end else begin
        // full lifetime of one pointer, ending in a double free
        a = random_pointer();
        add_item(MODE_ALLOC, a);
        add_item(MODE_QUERY, a);
        add_item(MODE_FREE, a);
        add_item(MODE_QUERY, a);
        add_item(MODE_FREE, a);
      end
    end
    total_items = pending.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || results_seen != items_taken);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d expected replies never arrived", expected_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
